FILE: rtl/core/ppgd_pkg.sv
// Shared types, constants and helpers for the packed-pixel graphics decoder.
// Used by ppgd_regs, ppgd_decode and the core top level; no dependencies.
package ppgd_pkg;

	localparam int unsigned PADDR_W  = 6;
	localparam int unsigned PDATA_W  = 64;
	localparam int unsigned NUM_PIX  = 8;
	localparam int unsigned PIX_W    = 4;
	localparam int unsigned COUNT_W  = 4;
	localparam int unsigned REPEAT_W = 3;

	// Mode decode constants
	localparam logic [7:0] CLASS_MASK = 8'h1a;
	localparam logic [7:0] CLASS_CGA  = 8'h0a;
	localparam logic [7:0] CLASS_HI16 = 8'h1a;
	localparam logic [7:0] M1_2COL    = 8'h04;
	localparam logic [7:0] M2_2COL    = 8'h08;
	localparam logic [7:0] PAGE_640   = 8'hc0;
	localparam logic [7:0] M1_HIRES   = 8'h01;
	localparam logic [3:0] NIB_MASK   = 4'h0f;

	// Register indexes, byte address is 8 * index
	typedef enum logic [2:0] {
		REG_MODE1   = 3'd0,
		REG_MODE2   = 3'd1,
		REG_PAGE    = 3'd2,
		REG_PMASK   = 3'd3,
		REG_PALETTE = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		MODE_NONE   = 3'd0,
		MODE_2C640  = 3'd1,
		MODE_4C640  = 3'd2,
		MODE_4C320  = 3'd3,
		MODE_16C320 = 3'd4,
		MODE_16C160 = 3'd5
	} mode_t;

	typedef struct packed {
		logic [7:0]  mode1;
		logic [7:0]  mode2;
		logic [7:0]  page;
		logic [3:0]  plane_mask;
		logic [63:0] palette;
	} cfg_t;

	typedef struct packed {
		logic [NUM_PIX-1:0][PIX_W-1:0] pix;
		logic [COUNT_W-1:0]            count;
		logic [REPEAT_W-1:0]           repeat_factor;
	} result_t;

	// Masked index into the sixteen-entry palette
	function automatic logic [PIX_W-1:0] pal_lookup(
		input logic [3:0]  idx,
		input logic [3:0]  msk,
		input logic [63:0] palette
	);
		logic [3:0] sel;
		sel = idx & msk & NIB_MASK;
		return palette[{sel, 2'b00} +: 4];
	endfunction

endpackage

FILE: rtl/core/packed_pixel_graphics_decoder_core.sv
// Packed-pixel graphics decoder core: input register, decode, result register.
// An accepted request is decoded from the input register and captured in the result register.
// Throughput: one request per cycle; the two pipeline registers advance together
// unless the result is held by out_stall.
// Reset: arst_n clears the valid flags and all configuration registers to zero.
// Depends on ppgd_pkg, ppgd_regs and ppgd_decode.
module packed_pixel_graphics_decoder_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ppgd_pkg::PADDR_W-1:0]      paddr,
	input  logic [ppgd_pkg::PDATA_W-1:0]      pwdata,
	output logic [ppgd_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        first_byte,
	input  logic [7:0]                        second_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ppgd_pkg::PIX_W-1:0]        pixel_0,
	output logic [ppgd_pkg::PIX_W-1:0]        pixel_1,
	output logic [ppgd_pkg::PIX_W-1:0]        pixel_2,
	output logic [ppgd_pkg::PIX_W-1:0]        pixel_3,
	output logic [ppgd_pkg::PIX_W-1:0]        pixel_4,
	output logic [ppgd_pkg::PIX_W-1:0]        pixel_5,
	output logic [ppgd_pkg::PIX_W-1:0]        pixel_6,
	output logic [ppgd_pkg::PIX_W-1:0]        pixel_7,
	output logic [ppgd_pkg::COUNT_W-1:0]      pixel_count,
	output logic [ppgd_pkg::REPEAT_W-1:0]     repeat_factor
);
	import ppgd_pkg::*;

	cfg_t       cfg;
	result_t    res;
	result_t    res_s2;
	logic [7:0] first_s1;
	logic [7:0] second_s1;
	logic       valid_s1;
	logic       valid_s2;
	logic       advance;
	logic       in_take;

	ppgd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ppgd_decode u_decode (
		.cfg         (cfg),
		.first_byte  (first_s1),
		.second_byte (second_s1),
		.res         (res)
	);

	// Pipeline moves whenever the result slot is free or being taken
	assign advance  = !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance)
				valid_s2 <= valid_s1;
			if (advance || !valid_s1)
				valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			first_s1  <= first_byte;
			second_s1 <= second_byte;
		end
		if (advance && valid_s1)
			res_s2 <= res;
	end

	assign out_valid     = valid_s2;
	assign pixel_0       = res_s2.pix[0];
	assign pixel_1       = res_s2.pix[1];
	assign pixel_2       = res_s2.pix[2];
	assign pixel_3       = res_s2.pix[3];
	assign pixel_4       = res_s2.pix[4];
	assign pixel_5       = res_s2.pix[5];
	assign pixel_6       = res_s2.pix[6];
	assign pixel_7       = res_s2.pix[7];
	assign pixel_count   = res_s2.count;
	assign repeat_factor = res_s2.repeat_factor;

	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_count == 4'd0 || pixel_count == 4'd2 ||
			pixel_count == 4'd4 || pixel_count == 4'd8))
		else $error("pixel_count outside the legal set");

	a_blank_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pixel_count == 4'd0) |->
			(repeat_factor == 3'd1 && pixel_0 == 4'd0 && pixel_1 == 4'd0))
		else $error("blank mode result carries pixels or repeat");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> valid_s1)
		else $error("accepted request lost at input register");

	a_move_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> valid_s2)
		else $error("decoded request lost at result register");

endmodule

FILE: rtl/core/ppgd_regs.sv
// APB-style configuration registers for the packed-pixel graphics decoder.
// Depends on ppgd_pkg for the register map and the cfg_t bundle.
module ppgd_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ppgd_pkg::PADDR_W-1:0]    paddr,
	input  logic [ppgd_pkg::PDATA_W-1:0]    pwdata,
	output logic [ppgd_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	output ppgd_pkg::cfg_t                  cfg
);
	import ppgd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_MODE1:   cfg_q.mode1      <= pwdata[7:0];
				REG_MODE2:   cfg_q.mode2      <= pwdata[7:0];
				REG_PAGE:    cfg_q.page       <= pwdata[7:0];
				REG_PMASK:   cfg_q.plane_mask <= pwdata[3:0];
				REG_PALETTE: cfg_q.palette    <= pwdata[63:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MODE1:   prdata = {56'd0, cfg_q.mode1};
			REG_MODE2:   prdata = {56'd0, cfg_q.mode2};
			REG_PAGE:    prdata = {56'd0, cfg_q.page};
			REG_PMASK:   prdata = {60'd0, cfg_q.plane_mask};
			REG_PALETTE: prdata = cfg_q.palette;
			default:     prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/ppgd_decode.sv
// Mode select and pixel unpack: turns one or two video bytes into palette outputs.
// Depends on ppgd_pkg; purely combinational, sits between the core's pipeline registers.
module ppgd_decode (
	input  ppgd_pkg::cfg_t    cfg,
	input  logic [7:0]        first_byte,
	input  logic [7:0]        second_byte,
	output ppgd_pkg::result_t res
);
	import ppgd_pkg::*;

	mode_t      mode;
	logic [7:0] cls;
	logic [3:0] mask2;

	assign cls   = cfg.mode1 & CLASS_MASK;
	assign mask2 = cfg.plane_mask & 4'h3;

	always_comb begin
		mode = MODE_NONE;
		if (cls == CLASS_CGA) begin
			if (|(cfg.mode1 & M1_2COL) && |(cfg.mode2 & M2_2COL))
				mode = MODE_2C640;
			else if ((cfg.page & PAGE_640) == PAGE_640)
				mode = MODE_4C640;
			else
				mode = MODE_4C320;
		end else if (cls == CLASS_HI16) begin
			mode = |(cfg.mode1 & M1_HIRES) ? MODE_16C320 : MODE_16C160;
		end
	end

	always_comb begin
		res = '0;
		res.repeat_factor = REPEAT_W'(1);
		unique case (mode)
			MODE_2C640: begin
				for (int k = 0; k < NUM_PIX; k++)
					res.pix[k] = pal_lookup({3'd0, first_byte[7-k]},
						cfg.plane_mask & 4'h1, cfg.palette);
				res.count = COUNT_W'(8);
			end
			MODE_4C640: begin
				for (int k = 0; k < NUM_PIX; k++)
					res.pix[k] = pal_lookup({2'd0, second_byte[7-k], first_byte[7-k]},
						mask2, cfg.palette);
				res.count = COUNT_W'(8);
			end
			MODE_4C320: begin
				for (int k = 0; k < 4; k++)
					res.pix[k] = pal_lookup({2'd0, first_byte[7-2*k -: 2]},
						mask2, cfg.palette);
				res.count         = COUNT_W'(4);
				res.repeat_factor = REPEAT_W'(2);
			end
			MODE_16C320, MODE_16C160: begin
				res.pix[0] = pal_lookup(first_byte[7:4], cfg.plane_mask, cfg.palette);
				res.pix[1] = pal_lookup(first_byte[3:0], cfg.plane_mask, cfg.palette);
				res.count  = COUNT_W'(2);
				res.repeat_factor = (mode == MODE_16C320) ? REPEAT_W'(2) : REPEAT_W'(4);
			end
			default: ;
		endcase
	end

endmodule
